FILE: rtl/core/rpdp_pkg.sv
`default_nettype none
package rpdp_pkg;

	// Screen geometry
	localparam int SCREEN_COLS = 80;
	localparam int SCREEN_ROWS = 45;
	localparam int CELLS = SCREEN_COLS * SCREEN_ROWS;
	localparam int CELL_W = $clog2(CELLS);
	localparam int RC_W = 9;
	localparam int HALF_COLS_SC = (SCREEN_COLS / 2) * 256;
	localparam int HALF_ROWS_SC = (SCREEN_ROWS / 2) * 256;

	// Field widths
	localparam int ROW_W = 6;
	localparam int COL_W = 7;
	localparam int DEPTH_W = 24;
	localparam int GLYPH_W = 8;
	localparam int WORD_W = DEPTH_W + GLYPH_W;

	localparam logic [GLYPH_W-1:0] BLANK_GLYPH = 8'd32;
	localparam logic [DEPTH_W-1:0] DEPTH_MAX = 24'hFFFFFF;

	// Request codes
	localparam logic [1:0] REQ_PLOT = 2'd0;
	localparam logic [1:0] REQ_CLEAR = 2'd1;
	localparam logic [1:0] REQ_READ = 2'd2;

	// Register indexes
	localparam logic [2:0] REG_SIN_A = 3'd0;
	localparam logic [2:0] REG_COS_A = 3'd1;
	localparam logic [2:0] REG_SIN_B = 3'd2;
	localparam logic [2:0] REG_COS_B = 3'd3;
	localparam logic [2:0] REG_SIN_C = 3'd4;
	localparam logic [2:0] REG_COS_C = 3'd5;
	localparam logic [2:0] REG_CENTER = 3'd6;
	localparam logic [2:0] REG_SCREEN = 3'd7;

	// Work kinds after classification
	localparam logic [1:0] K_PLOT = 2'd0;
	localparam logic [1:0] K_CLEAR = 2'd1;
	localparam logic [1:0] K_READ = 2'd2;
	localparam logic [1:0] K_NOP = 2'd3;

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);

	typedef struct packed {
		logic [1:0] kind;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic [GLYPH_W-1:0] glyph;
		logic hit;
		logic [CELL_W-1:0] idx;
	} item_t;

endpackage
`default_nettype wire

FILE: rtl/core/rpdp_ram.sv
`default_nettype none
module rpdp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one word, read one word registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

FILE: rtl/core/rpdp_front.sv
`default_nettype none
module rpdp_front (
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [1:0] req_type,
	input wire logic signed [15:0] point_x,
	input wire logic signed [15:0] point_y,
	input wire logic signed [15:0] point_z,
	input wire logic [rpdp_pkg::GLYPH_W-1:0] glyph,
	input wire logic [rpdp_pkg::ROW_W-1:0] cell_row,
	input wire logic [rpdp_pkg::COL_W-1:0] cell_col,
	input wire logic q_full,
	input wire logic init_busy,
	output logic push,
	output rpdp_pkg::item_t item
);

	logic hit;

	// Hold the channel while the queue is full or the store is being swept after reset
	assign in_stall = q_full | init_busy;
	assign push = in_valid & ~in_stall;

	assign hit = (32'(cell_row) < 32'(rpdp_pkg::SCREEN_ROWS)) &&
		(32'(cell_col) < 32'(rpdp_pkg::SCREEN_COLS));

	// Classify the request and resolve the read address
	always_comb begin
		item.x = point_x;
		item.y = point_y;
		item.z = point_z;
		item.glyph = glyph;
		item.hit = hit;
		item.idx = rpdp_pkg::CELL_W'(32'(cell_row) * rpdp_pkg::SCREEN_COLS +
			32'(cell_col));
		unique case (req_type)
			rpdp_pkg::REQ_PLOT: item.kind = rpdp_pkg::K_PLOT;
			rpdp_pkg::REQ_CLEAR: item.kind = rpdp_pkg::K_CLEAR;
			rpdp_pkg::REQ_READ: item.kind = rpdp_pkg::K_READ;
			default: item.kind = rpdp_pkg::K_NOP;
		endcase
	end

endmodule
`default_nettype wire

FILE: rtl/core/rpdp_queue.sv
`default_nettype none
module rpdp_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire rpdp_pkg::item_t push_item,
	input wire logic pop,
	output rpdp_pkg::item_t head,
	output logic full,
	output logic empty
);

	rpdp_pkg::item_t ent_q [rpdp_pkg::Q_DEPTH];
	logic [rpdp_pkg::Q_PTR_W-1:0] wp_q;
	logic [rpdp_pkg::Q_PTR_W-1:0] rp_q;
	logic [rpdp_pkg::Q_PTR_W:0] cnt_q;

	assign full = (cnt_q == (rpdp_pkg::Q_PTR_W+1)'(rpdp_pkg::Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign head = ent_q[rp_q];

	// Store the entry
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= push_item;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == rpdp_pkg::Q_PTR_W'(rpdp_pkg::Q_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == rpdp_pkg::Q_PTR_W'(rpdp_pkg::Q_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/rpdp_div.sv
`default_nettype none
module rpdp_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [47:0] dvd,
	input wire logic [47:0] dsr,
	input wire logic [4:0] cnt,
	output logic done,
	output logic [24:0] quo
);

	logic [47:0] rem_q;
	logic [47:0] ds_q;
	logic [4:0] cnt_q;
	logic run_q;
	logic done_q;
	logic ge;

	assign ge = rem_q >= ds_q;
	assign done = done_q;

	// Restoring divide: one quotient bit per cycle, divisor shifts right
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dvd;
			ds_q <= dsr;
			quo <= '0;
		end else if (run_q) begin
			rem_q <= ge ? rem_q - ds_q : rem_q;
			ds_q <= ds_q >> 1;
			quo <= {quo[23:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= !start && run_q && (cnt_q == '0);
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= cnt;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q <= 1'b0;
				end
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/rpdp_back.sv
`default_nettype none
module rpdp_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_idx,
	input wire logic [15:0] cfg_data,
	input wire rpdp_pkg::item_t head,
	input wire logic q_empty,
	output logic pop,
	output logic init_busy,
	output logic out_valid,
	input wire logic out_stall,
	output logic on_screen,
	output logic plotted,
	output logic [rpdp_pkg::GLYPH_W-1:0] cell_glyph,
	output logic [rpdp_pkg::DEPTH_W-1:0] cell_depth
);

	localparam logic [3:0] S_INIT = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_CLR = 4'd2;
	localparam logic [3:0] S_MUL = 4'd3;
	localparam logic [3:0] S_PROJ = 4'd4;
	localparam logic [3:0] S_CDIV = 4'd5;
	localparam logic [3:0] S_RDIV = 4'd6;
	localparam logic [3:0] S_DDIV = 4'd7;
	localparam logic [3:0] S_RD = 4'd8;
	localparam logic [3:0] S_CMP = 4'd9;
	localparam logic [3:0] S_RES = 4'd10;

	localparam logic [4:0] LAST_STEP = 5'd25;

	logic [3:0] state_q;

	// Configuration
	logic signed [15:0] sin_a_q, cos_a_q, sin_b_q, cos_b_q, sin_c_q, cos_c_q;
	logic [15:0] center_q, screen_q;

	// Item
	logic [1:0] kind_q;
	logic signed [15:0] x_q, y_q, z_q;
	logic [rpdp_pkg::GLYPH_W-1:0] glyph_q;
	logic [rpdp_pkg::CELL_W-1:0] idx_q;
	logic [rpdp_pkg::CELL_W-1:0] clr_q;

	// Rotation datapath
	logic [4:0] st_q;
	logic signed [23:0] op_a, op_b;
	logic signed [47:0] p_q;
	logic signed [47:0] acc_q;
	logic signed [47:0] wsum;
	logic signed [19:0] f;
	logic signed [19:0] ss_q, cs_q;
	logic signed [19:0] kxx_q, kxy_q, kxz_q, kyx_q, kyy_q, kyz_q, kzy_q, kzz_q;
	logic signed [23:0] rx_q, ry_q, rz_q;
	logic signed [47:0] sdrx_q, sdry_q;

	// Projection
	logic signed [41:0] rz42;
	logic signed [41:0] n_col, n_row;
	logic [41:0] m_col, m_row;
	logic [rpdp_pkg::RC_W-1:0] col_q, row_q;
	logic [rpdp_pkg::DEPTH_W-1:0] depth_q;
	logic col_ok, row_ok;

	// Divider
	logic div_start;
	logic [47:0] div_dvd, div_dsr;
	logic [4:0] div_cnt;
	logic div_done;
	logic [24:0] div_quo;

	// Store
	logic ram_we;
	logic [rpdp_pkg::CELL_W-1:0] ram_waddr;
	logic [rpdp_pkg::WORD_W-1:0] ram_wdata, ram_rdata;
	logic depth_gt;

	// Result staging
	logic res_on_q, res_plot_q;
	logic [rpdp_pkg::GLYPH_W-1:0] res_glyph_q;
	logic [rpdp_pkg::DEPTH_W-1:0] res_depth_q;
	logic out_free;

	assign init_busy = (state_q == S_INIT);
	assign pop = (state_q == S_IDLE) && !q_empty;
	assign out_free = !out_valid || !out_stall;

	// Select multiplier operands for each step
	always_comb begin
		unique case (st_q)
			5'd0: begin op_a = 24'(sin_a_q); op_b = 24'(sin_b_q); end
			5'd1: begin op_a = 24'(cos_a_q); op_b = 24'(sin_b_q); end
			5'd2: begin op_a = 24'(cos_b_q); op_b = 24'(cos_c_q); end
			5'd3: begin op_a = 24'(ss_q); op_b = 24'(cos_c_q); end
			5'd4: begin op_a = 24'(cos_a_q); op_b = 24'(sin_c_q); end
			5'd5: begin op_a = 24'(sin_a_q); op_b = 24'(sin_c_q); end
			5'd6: begin op_a = 24'(cs_q); op_b = 24'(cos_c_q); end
			5'd7: begin op_a = 24'(cos_b_q); op_b = 24'(sin_c_q); end
			5'd8: begin op_a = 24'(cos_a_q); op_b = 24'(cos_c_q); end
			5'd9: begin op_a = 24'(ss_q); op_b = 24'(sin_c_q); end
			5'd10: begin op_a = 24'(sin_a_q); op_b = 24'(cos_c_q); end
			5'd11: begin op_a = 24'(cs_q); op_b = 24'(sin_c_q); end
			5'd12: begin op_a = 24'(sin_a_q); op_b = 24'(cos_b_q); end
			5'd13: begin op_a = 24'(cos_a_q); op_b = 24'(cos_b_q); end
			5'd14: begin op_a = 24'(x_q); op_b = 24'(kxx_q); end
			5'd15: begin op_a = 24'(y_q); op_b = 24'(kxy_q); end
			5'd16: begin op_a = 24'(z_q); op_b = 24'(kxz_q); end
			5'd17: begin op_a = 24'(x_q); op_b = 24'(kyx_q); end
			5'd18: begin op_a = 24'(y_q); op_b = 24'(kyy_q); end
			5'd19: begin op_a = 24'(z_q); op_b = 24'(kyz_q); end
			5'd20: begin op_a = 24'(x_q); op_b = 24'(sin_b_q); end
			5'd21: begin op_a = 24'(y_q); op_b = 24'(kzy_q); end
			5'd22: begin op_a = 24'(z_q); op_b = 24'(kzz_q); end
			5'd23: begin op_a = $signed({8'd0, screen_q}); op_b = rx_q; end
			5'd24: begin op_a = $signed({8'd0, screen_q}); op_b = ry_q; end
			default: begin op_a = '0; op_b = '0; end
		endcase
	end

	assign f = p_q[33:14];
	assign wsum = acc_q + p_q;

	// Projection numerators and their magnitudes
	assign rz42 = 42'(rz_q);
	assign n_col = rz42 * 42'(rpdp_pkg::HALF_COLS_SC) + (42'(sdrx_q) <<< 1);
	assign n_row = rz42 * 42'(rpdp_pkg::HALF_ROWS_SC) + 42'(sdry_q);
	assign m_col = n_col[41] ? 42'(-n_col) : n_col;
	assign m_row = n_row[41] ? 42'(-n_row) : n_row;

	// Quotient bit eight flags an off-screen result
	assign col_ok = !div_quo[8] && (n_col[41] ? (div_quo[7:0] == '0) :
		(32'(div_quo[7:0]) < 32'(rpdp_pkg::SCREEN_COLS)));
	assign row_ok = !div_quo[8] && (n_row[41] ? (div_quo[7:0] == '0) :
		(32'(div_quo[7:0]) < 32'(rpdp_pkg::SCREEN_ROWS)));

	// Launch column, row and depth divides
	always_comb begin
		div_start = 1'b0;
		div_dvd = {6'd0, m_col};
		div_dsr = 48'({rz_q, 16'd0});
		div_cnt = 5'd8;
		unique case (state_q)
			S_PROJ: div_start = !(rz_q[23] || rz_q == '0);
			S_CDIV: begin
				div_start = div_done && col_ok;
				div_dvd = {6'd0, m_row};
			end
			S_RDIV: begin
				div_start = div_done && row_ok;
				div_dvd = 48'(25'h1000000);
				div_dsr = {rz_q, 24'd0};
				div_cnt = 5'd24;
			end
			default: ;
		endcase
	end

	rpdp_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dvd(div_dvd),
		.dsr(div_dsr),
		.cnt(div_cnt),
		.done(div_done),
		.quo(div_quo)
	);

	// Store port: sweep writes blanks, depth test writes the new cell
	assign depth_gt = depth_q > ram_rdata[rpdp_pkg::WORD_W-1:rpdp_pkg::GLYPH_W];
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = {depth_q, glyph_q};
		if (state_q == S_INIT || state_q == S_CLR) begin
			ram_we = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = {{rpdp_pkg::DEPTH_W{1'b0}}, rpdp_pkg::BLANK_GLYPH};
		end else if (state_q == S_CMP && kind_q == rpdp_pkg::K_PLOT) begin
			ram_we = depth_gt;
		end
	end

	rpdp_ram #(
		.WIDTH(rpdp_pkg::WORD_W),
		.DEPTH(rpdp_pkg::CELLS)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	// Datapath registers
	always_ff @(posedge clk) begin
		p_q <= op_a * op_b;
		if (state_q == S_MUL) begin
			case (st_q)
				5'd1: ss_q <= f;
				5'd2: cs_q <= f;
				5'd3: kxx_q <= f;
				5'd4: kxy_q <= f;
				5'd5: kxy_q <= kxy_q + f;
				5'd6: kxz_q <= f;
				5'd7: kxz_q <= kxz_q - f;
				5'd8: kyx_q <= -f;
				5'd9: kyy_q <= f;
				5'd10: kyy_q <= kyy_q - f;
				5'd11: kyz_q <= f;
				5'd12: kyz_q <= kyz_q + f;
				5'd13: kzy_q <= -f;
				5'd14: kzz_q <= f;
				5'd15, 5'd18, 5'd21: acc_q <= p_q;
				5'd16, 5'd19, 5'd22: acc_q <= wsum;
				5'd17: rx_q <= wsum[37:14];
				5'd20: ry_q <= wsum[37:14];
				5'd23: rz_q <= wsum[37:14] + $signed({8'd0, center_q});
				5'd24: sdrx_q <= p_q;
				5'd25: sdry_q <= p_q;
				default: ;
			endcase
		end
		if (pop) begin
			kind_q <= head.kind;
			x_q <= head.x;
			y_q <= head.y;
			z_q <= head.z;
			glyph_q <= head.glyph;
			idx_q <= head.idx;
		end
		if (state_q == S_CDIV && div_done) begin
			col_q <= rpdp_pkg::RC_W'(div_quo[7:0]);
		end
		if (state_q == S_RDIV && div_done) begin
			row_q <= rpdp_pkg::RC_W'(div_quo[7:0]);
		end
		if (state_q == S_DDIV && div_done) begin
			depth_q <= div_quo[24] ? rpdp_pkg::DEPTH_MAX : div_quo[23:0];
			idx_q <= rpdp_pkg::CELL_W'(32'(row_q) * rpdp_pkg::SCREEN_COLS + 32'(col_q));
		end
		if (out_free && state_q == S_RES) begin
			on_screen <= res_on_q;
			plotted <= res_plot_q;
			cell_glyph <= res_glyph_q;
			cell_depth <= res_depth_q;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			clr_q <= '0;
			st_q <= '0;
			out_valid <= 1'b0;
			res_on_q <= 1'b0;
			res_plot_q <= 1'b0;
			res_glyph_q <= '0;
			res_depth_q <= '0;
			sin_a_q <= '0;
			cos_a_q <= 16'sd16384;
			sin_b_q <= '0;
			cos_b_q <= 16'sd16384;
			sin_c_q <= '0;
			cos_c_q <= 16'sd16384;
			center_q <= 16'd25600;
			screen_q <= 16'd10240;
		end else begin
			// Write configuration
			if (cfg_we) begin
				unique case (cfg_idx)
					rpdp_pkg::REG_SIN_A: sin_a_q <= cfg_data;
					rpdp_pkg::REG_COS_A: cos_a_q <= cfg_data;
					rpdp_pkg::REG_SIN_B: sin_b_q <= cfg_data;
					rpdp_pkg::REG_COS_B: cos_b_q <= cfg_data;
					rpdp_pkg::REG_SIN_C: sin_c_q <= cfg_data;
					rpdp_pkg::REG_COS_C: cos_c_q <= cfg_data;
					rpdp_pkg::REG_CENTER: center_q <= cfg_data;
					rpdp_pkg::REG_SCREEN: screen_q <= cfg_data;
					default: ;
				endcase
			end

			// Drop the output once taken
			if (out_valid && !out_stall && state_q != S_RES) begin
				out_valid <= 1'b0;
			end

			unique case (state_q)
				S_INIT, S_CLR: begin
					if (clr_q == rpdp_pkg::CELL_W'(rpdp_pkg::CELLS - 1)) begin
						clr_q <= '0;
						state_q <= (state_q == S_INIT) ? S_IDLE : S_RES;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (!q_empty) begin
						res_on_q <= 1'b0;
						res_plot_q <= 1'b0;
						res_glyph_q <= (head.kind == rpdp_pkg::K_READ && !head.hit) ?
							rpdp_pkg::BLANK_GLYPH : '0;
						res_depth_q <= '0;
						unique case (head.kind)
							rpdp_pkg::K_PLOT: begin
								st_q <= '0;
								state_q <= S_MUL;
							end
							rpdp_pkg::K_CLEAR: state_q <= S_CLR;
							rpdp_pkg::K_READ: state_q <= head.hit ? S_RD : S_RES;
							default: state_q <= S_RES;
						endcase
					end
				end
				S_MUL: begin
					st_q <= st_q + 1'b1;
					if (st_q == LAST_STEP) begin
						state_q <= S_PROJ;
					end
				end
				S_PROJ: state_q <= div_start ? S_CDIV : S_RES;
				S_CDIV: begin
					if (div_done) begin
						state_q <= col_ok ? S_RDIV : S_RES;
					end
				end
				S_RDIV: begin
					if (div_done) begin
						state_q <= row_ok ? S_DDIV : S_RES;
					end
				end
				S_DDIV: begin
					if (div_done) begin
						state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_CMP;
				S_CMP: begin
					if (kind_q == rpdp_pkg::K_READ) begin
						res_glyph_q <= ram_rdata[rpdp_pkg::GLYPH_W-1:0];
						res_depth_q <= ram_rdata[rpdp_pkg::WORD_W-1:rpdp_pkg::GLYPH_W];
					end else begin
						res_on_q <= 1'b1;
						res_plot_q <= depth_gt;
					end
					state_q <= S_RES;
				end
				S_RES: begin
					if (out_free) begin
						out_valid <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/rotate_project_depth_plot.sv
`default_nettype none
// Channel   Direction  Handshake          Payload
// in        input      in_valid/in_stall  req_type point_x point_y point_z glyph cell_row cell_col
// out       output     out_valid/out_stall on_screen plotted cell_glyph cell_depth
// cfg       input      cfg_we             cfg_idx cfg_data
//
// A plot takes 26 steps of the shared 24x24 multiplier, then column and row
// divides and a depth divide, all on one shift-subtract divider, then a store read
// and depth test. A read of an on-screen cell goes straight to the store read;
// a clear sweeps the store, one cell per cycle. After reset the same sweep runs
// and in_stall stays high. A two-entry queue takes requests while the back end
// works, and the output register frees the back end while a result waits under
// out_stall.
module rotate_project_depth_plot (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_idx,
	input wire logic [15:0] cfg_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [1:0] req_type,
	input wire logic signed [15:0] point_x,
	input wire logic signed [15:0] point_y,
	input wire logic signed [15:0] point_z,
	input wire logic [7:0] glyph,
	input wire logic [5:0] cell_row,
	input wire logic [6:0] cell_col,
	output logic out_valid,
	input wire logic out_stall,
	output logic on_screen,
	output logic plotted,
	output logic [7:0] cell_glyph,
	output logic [23:0] cell_depth
);

	rpdp_pkg::item_t push_item;
	rpdp_pkg::item_t head;
	logic push, pop, q_full, q_empty, init_busy;

	rpdp_front u_front (
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.point_x(point_x),
		.point_y(point_y),
		.point_z(point_z),
		.glyph(glyph),
		.cell_row(cell_row),
		.cell_col(cell_col),
		.q_full(q_full),
		.init_busy(init_busy),
		.push(push),
		.item(push_item)
	);

	rpdp_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.pop(pop),
		.head(head),
		.full(q_full),
		.empty(q_empty)
	);

	rpdp_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.head(head),
		.q_empty(q_empty),
		.pop(pop),
		.init_busy(init_busy),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.on_screen(on_screen),
		.plotted(plotted),
		.cell_glyph(cell_glyph),
		.cell_depth(cell_depth)
	);

endmodule
`default_nettype wire
